// File: hdl/assert_macros.svh
// Assertion macros shared by the card track parser RTL.
// Each macro builds one labeled concurrent assertion on a clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ctfp_pkg.sv
// Types and constants for the card track field parser.
// No dependencies; used by the front, queue, back and top-level files.
package ctfp_pkg;

    localparam logic [7:0]  CH_CARET     = 8'h5E;
    localparam logic [7:0]  CH_SLASH     = 8'h2F;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [47:0] PREFIX_RESET = 48'h363030383437;
    localparam logic [3:0]  POS_MAX      = 4'd15;
    localparam logic [3:0]  PFX_FIRST    = 4'd2;
    localparam logic [3:0]  PFX_LAST     = 4'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_PRE   = 4'b0001,  // before caret
        PH_NAME  = 4'b0010,  // in surname
        PH_AFTER = 4'b0100,  // after slash
        PH_DONE  = 4'b1000   // initial taken
    } ctfp_phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PREFIX   = 2'd1,
        ST_NO_CARET = 2'd2,
        ST_NO_SLASH = 2'd3
    } ctfp_status_t;

    // one queued result request from the front
    typedef struct packed {
        logic        final_rec;  // 1: end-of-string record
        logic [7:0]  ch;         // raw surname character
        logic        lower;      // lowercase this surname character
        logic [31:0] id;
        logic [7:0]  init;
        logic        bad;        // prefix mismatch or short string
        ctfp_phase_t phase;      // phase after this character
    } ctfp_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ctfp_qstat_t;

endpackage

// File: hdl/card_track_field_parser_core.sv
// Card track field parser, top level.
// Channels: s_ takes one track character a request (s_tdata[7:0]), s_tlast marks
//   the last character of a string; cfg_ writes the 48-bit issuer prefix and is
//   always ready (write only between strings).
// Results on m_: m_tuser[0] is 0 for a surname character, 1 for the final record.
//   m_tdata from bit 0: name_char[7:0], card_id[39:8], first_initial[47:40],
//   status[49:48], zero fill.
// Throughput: one character per cycle while the queue is not full. The id
//   window is kept as a running decimal value updated once per character (one
//   constant multiply and add). Each result is written into the queue when its
//   character is accepted and moved to the output register once it heads the
//   queue and the output register is free or being taken.
// Reset clears all parse state and loads the default prefix "600847".
// When m_tready is low the output register holds, the two-entry queue fills, and
//   s_tready drops only once the queue is full; characters that give no result
//   are held back with the rest.
// Depends on ctfp_pkg, ctfp_front, ctfp_queue and ctfp_back.
module card_track_field_parser_core
    import ctfp_pkg::*;
#(
    parameter int ID_DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // track_char[7:0]
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // name_char, card_id, first_initial, status, zero fill
    output logic [0:0]  m_tuser    // record_kind
);

    ctfp_entry_t push_entry, pop_entry;
    ctfp_qstat_t qstat;
    logic        push, pop, in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !qstat.full;
    assign in_accept = s_tvalid && s_tready;

    ctfp_front #(
        .ID_DIGITS (ID_DIGITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .track_char    (s_tdata),
        .end_of_string (s_tlast),
        .push          (push),
        .push_entry    (push_entry)
    );

    ctfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (qstat)
    );

    ctfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_entry  (pop_entry),
        .q_valid  (!qstat.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/ctfp_front.sv
// Front end: takes characters, tracks position, prefix, phase and the id window,
// and posts result requests. Depends on ctfp_pkg.
module ctfp_front
    import ctfp_pkg::*;
#(
    parameter int ID_DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [47:0] cfg_data,
    input  logic        in_accept,
    input  logic [7:0]  track_char,
    input  logic        end_of_string,
    output logic        push,
    output ctfp_entry_t push_entry
);

    localparam int HIST_D = ID_DIGITS + 2;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    localparam logic [31:0] LEAD_W = pow10(ID_DIGITS);
    // folds the -48 of the leaving digit and of the entering digit
    localparam logic [31:0] WIN_K  = 32'(LEAD_W * 32'd48) - 32'd48;

    logic [47:0]  prefix_reg;
    logic [3:0]   pos_reg, pos_next;
    logic         good_reg, good_next;
    ctfp_phase_t  phase_reg, phase_next;
    logic [7:0]   hist_reg [HIST_D];
    logic [31:0]  win_reg, win_next;
    logic [31:0]  id_reg, id_next;
    logic [7:0]   init_reg, init_next;
    logic         started_reg, started_next;

    logic         in_pfx;
    logic [2:0]   pfx_sel;
    logic [7:0]   pfx_want;
    logic [31:0]  lead_term;
    logic         emit_name;

    always_comb begin
        in_pfx    = (pos_reg >= PFX_FIRST) && (pos_reg <= PFX_LAST);
        pfx_sel   = 3'(PFX_LAST[2:0] - pos_reg[2:0]);
        pfx_want  = prefix_reg[{pfx_sel, 3'b000} +: 8];
        good_next = good_reg && !(in_pfx && (track_char != pfx_want));
        pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 4'd1;

        // sliding decimal value of the window two to ID_DIGITS+1 places back
        lead_term = 32'(hist_reg[HIST_D-1]) * LEAD_W;
        win_next  = (win_reg << 3) + (win_reg << 1) - lead_term + WIN_K
                    + 32'(hist_reg[1]);
    end

    always_comb begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        init_next    = init_reg;
        started_next = started_reg;
        emit_name    = 1'b0;
        case (phase_reg)
            PH_PRE: begin
                if (track_char == CH_CARET) begin
                    id_next      = win_reg;
                    phase_next   = PH_NAME;
                    started_next = 1'b0;
                end
            end
            PH_NAME: begin
                if (track_char == CH_SLASH) begin
                    phase_next = PH_AFTER;
                end else begin
                    emit_name    = 1'b1;
                    started_next = 1'b1;
                end
            end
            PH_AFTER: begin
                init_next  = track_char;
                phase_next = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
                phase_next = PH_PRE;
            end
        endcase
    end

    always_comb begin
        push                 = in_accept && (end_of_string || emit_name);
        push_entry.final_rec = end_of_string;
        push_entry.ch        = track_char;
        push_entry.lower     = started_reg;
        push_entry.id        = id_next;
        push_entry.init      = init_next;
        push_entry.bad       = !good_next || (pos_reg < PFX_LAST);
        push_entry.phase     = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= PREFIX_RESET;
        end else if (cfg_valid) begin
            prefix_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && end_of_string)) begin
            pos_reg     <= '0;
            good_reg    <= 1'b1;
            phase_reg   <= PH_PRE;
            win_reg     <= '0;
            id_reg      <= '0;
            init_reg    <= '0;
            started_reg <= 1'b0;
            for (int i = 0; i < HIST_D; i++) begin
                hist_reg[i] <= CH_ZERO;
            end
        end else if (in_accept) begin
            pos_reg     <= pos_next;
            good_reg    <= good_next;
            phase_reg   <= phase_next;
            win_reg     <= win_next;
            id_reg      <= id_next;
            init_reg    <= init_next;
            started_reg <= started_next;
            hist_reg[0] <= track_char;
            for (int i = 1; i < HIST_D; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

// File: hdl/ctfp_queue.sv
// Short request queue between the front and back ends.
// Depends on ctfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctfp_queue
    import ctfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ctfp_entry_t push_entry,
    input  logic        pop,
    output ctfp_entry_t pop_entry,
    output ctfp_qstat_t stat
);

    ctfp_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, aclk, aresetn, push, !stat.full, "push into full queue")
    `ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, pop, !stat.empty, "pop from empty queue")
    `ASSERT_NEXT(a_push_fills, aclk, aresetn, push && !pop, !stat.empty, "push lost")

endmodule

// File: hdl/ctfp_back.sv
// Back end: turns queued requests into result items in an output register.
// Depends on ctfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctfp_back
    import ctfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ctfp_entry_t q_entry,
    input  logic        q_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [0:0]  m_tuser
);

    logic         out_valid_reg;
    logic         kind_reg, kind_next;
    logic [7:0]   name_reg, name_next;
    logic [31:0]  id_reg, id_next;
    logic [7:0]   init_reg, init_next;
    ctfp_status_t st_reg, st_next;
    ctfp_status_t st_calc;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
    endfunction

    assign pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        if (q_entry.bad) begin
            st_calc = ST_PREFIX;
        end else if (q_entry.phase == PH_PRE) begin
            st_calc = ST_NO_CARET;
        end else if (q_entry.phase == PH_NAME) begin
            st_calc = ST_NO_SLASH;
        end else begin
            st_calc = ST_OK;
        end

        kind_next = q_entry.final_rec;
        if (q_entry.final_rec) begin
            name_next = '0;
            st_next   = st_calc;
            id_next   = (st_calc == ST_OK) ? q_entry.id : '0;
            init_next = (st_calc == ST_OK) ? q_entry.init : '0;
        end else begin
            name_next = q_entry.lower ? to_lower(q_entry.ch) : q_entry.ch;
            st_next   = ST_OK;
            id_next   = '0;
            init_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= kind_next;
            name_reg <= name_next;
            id_reg   <= id_next;
            init_reg <= init_next;
            st_reg   <= st_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'b0, st_reg, init_reg, id_reg, name_reg};

    `ASSERT_IMPLY(a_bad_status_clean, aclk, aresetn, out_valid_reg && (st_reg != ST_OK),
        (id_reg == '0) && (init_reg == '0), "failed record carries id or initial")
    `ASSERT_IMPLY(a_name_rec_ok, aclk, aresetn, out_valid_reg && !kind_reg,
        (st_reg == ST_OK) && (id_reg == '0), "surname record carries status or id")
    `ASSERT_NEXT(a_hold_stalled, aclk, aresetn, out_valid_reg && !m_tready,
        out_valid_reg && $stable(name_reg) && $stable(st_reg), "stalled result changed")

endmodule
